// File: hw/rtl/bpit_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpit_pkg
// Widths, latencies and types shared by the point-in-triangle pipeline.
// ----------------------------------------------------------------------------
package bpit_pkg;

    localparam int CRD_W = 32;         // Q16.16 coordinate
    localparam int DIF_W = 33;         // coordinate difference
    localparam int CRS_W = 66;         // cross product component
    localparam int DOT_W = 133;        // signed dot product
    localparam int SQ_W  = 132;        // squared length, unsigned
    localparam int REM_W = 139;        // divider remainder
    localparam int QUO_W = 38;         // ratio quotient, 2^32 scaled
    localparam int WGT_W = 20;         // Q3.16 weight

    localparam int PRE_STEPS  = 6;
    localparam int DIV_STEPS  = 38;
    localparam int SQRT_STEPS = 19;

    localparam int CROSS_LAT = 2;
    localparam int DOT_LAT   = 4;
    localparam int RATIO_LAT = 1 + DIV_STEPS + SQRT_STEPS + 1;

    localparam logic [WGT_W-1:0] WGT_MAX     = 20'd524287;
    localparam logic [WGT_W-1:0] WGT_NEG_MAG = 20'd524288;
    localparam logic [WGT_W-1:0] ONE_Q16     = 20'd65536;

    typedef logic signed [DIF_W-1:0] t_dif;
    typedef logic signed [CRS_W-1:0] t_crs;
    typedef logic signed [DOT_W-1:0] t_dot;
    typedef t_dif t_dif_vec [3];
    typedef t_crs t_crs_vec [3];

endpackage
`default_nettype wire

// File: hw/rtl/bpit_cross.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpit_cross
// Two-stage cross product of two difference vectors.
// ----------------------------------------------------------------------------
module bpit_cross (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire bpit_pkg::t_dif_vec  i_a,
    input  wire bpit_pkg::t_dif_vec  i_b,
    output bpit_pkg::t_crs_vec       o_c
);

    localparam int CW = bpit_pkg::CRS_W;

    logic signed [CW-1:0] r_m1 [3];
    logic signed [CW-1:0] r_m2 [3];

    for (genvar k = 0; k < 3; k++) begin : g_comp
        localparam int I1 = (k + 1) % 3;
        localparam int I2 = (k + 2) % 3;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m1[k] <= i_a[I1] * i_b[I2];
                r_m2[k] <= i_a[I2] * i_b[I1];
                o_c[k]  <= r_m1[k] - r_m2[k];
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bpit_dot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpit_dot
// Four-stage exact dot product of two 66-bit vectors, split into
// 33-bit partial products.
// ----------------------------------------------------------------------------
module bpit_dot (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire bpit_pkg::t_crs_vec  i_a,
    input  wire bpit_pkg::t_crs_vec  i_b,
    output bpit_pkg::t_dot           o_dot
);

    localparam int DW = bpit_pkg::DOT_W;
    localparam int HW = bpit_pkg::CRS_W / 2;

    logic signed [2*HW-1:0] r_hh [3];
    logic signed [2*HW:0]   r_hl [3];
    logic signed [2*HW:0]   r_lh [3];
    logic        [2*HW-1:0] r_ll [3];
    logic signed [DW-1:0]   r_x  [3];
    logic signed [2*HW+1:0] r_y  [3];
    logic signed [DW-1:0]   r_p  [3];

    for (genvar k = 0; k < 3; k++) begin : g_comp
        logic signed [HW-1:0] ah, bh;
        logic        [HW-1:0] al, bl;

        assign ah = i_a[k][2*HW-1:HW];
        assign al = i_a[k][HW-1:0];
        assign bh = i_b[k][2*HW-1:HW];
        assign bl = i_b[k][HW-1:0];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_hh[k] <= ah * bh;
                r_hl[k] <= ah * $signed({1'b0, bl});
                r_lh[k] <= $signed({1'b0, al}) * bh;
                r_ll[k] <= al * bl;
                r_x[k]  <= (DW'(r_hh[k]) << (2 * HW)) + DW'(r_ll[k]);
                r_y[k]  <= (2*HW+2)'(r_hl[k]) + (2*HW+2)'(r_lh[k]);
                r_p[k]  <= r_x[k] + (DW'(r_y[k]) << HW);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_dot <= r_p[0] + r_p[1] + r_p[2];
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/bpit_ratio.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpit_ratio
// Pipelined floor(65536*sqrt(s/t)): restoring divider, one quotient bit a
// stage, then a digit-by-digit square root, then sign and saturation.
// ----------------------------------------------------------------------------
module bpit_ratio (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic [bpit_pkg::SQ_W-1:0]             i_s,
    input  wire logic [bpit_pkg::SQ_W-1:0]             i_t,
    input  wire logic                                  i_neg,
    output logic signed [bpit_pkg::WGT_W-1:0]          o_weight,
    output logic                                       o_inr
);

    localparam int RW  = bpit_pkg::REM_W;
    localparam int SW  = bpit_pkg::SQ_W;
    localparam int QW  = bpit_pkg::QUO_W;
    localparam int WW  = bpit_pkg::WGT_W;
    localparam int PRE = bpit_pkg::PRE_STEPS;
    localparam int DIV = bpit_pkg::DIV_STEPS;
    localparam int SQR = bpit_pkg::SQRT_STEPS;
    localparam int CHN = DIV + SQR;

    logic [RW-1:0] r_rem [0:DIV];
    logic [SW-1:0] r_t   [0:DIV-1];
    logic [QW-1:0] r_q   [0:DIV];
    logic [QW-1:0] r_v   [1:SQR];
    logic [QW-1:0] r_res [1:SQR];
    logic          r_sat [0:CHN];
    logic          r_neg [0:CHN];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= RW'(i_s);
            r_t[0]   <= i_t;
            r_q[0]   <= '0;
            r_sat[0] <= RW'(i_s) >= (RW'(i_t) << PRE);
            r_neg[0] <= i_neg;
        end
    end

    for (genvar j = 0; j < DIV; j++) begin : g_div
        localparam int SH = (j < PRE) ? (PRE - 1 - j) : 0;
        logic [RW-1:0] cand, dsr;
        logic          ge;

        if (j < PRE) begin : g_pre
            assign cand = r_rem[j];
        end else begin : g_frac
            assign cand = r_rem[j] << 1;
        end
        assign dsr = RW'(r_t[j]) << SH;
        assign ge  = cand >= dsr;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= ge ? cand - dsr : cand;
                r_q[j+1]   <= r_q[j] | (ge ? (QW'(1) << (QW - 1 - j)) : '0);
                r_sat[j+1] <= r_sat[j];
                r_neg[j+1] <= r_neg[j];
            end
        end

        if (j < DIV - 1) begin : g_t
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_t[j+1] <= r_t[j];
                end
            end
        end
    end

    for (genvar m = 0; m < SQR; m++) begin : g_sqrt
        logic [QW-1:0] v_cur, res_cur, bitv, trial;

        if (m == 0) begin : g_first
            assign v_cur   = r_q[DIV];
            assign res_cur = '0;
        end else begin : g_next
            assign v_cur   = r_v[m];
            assign res_cur = r_res[m];
        end
        assign bitv  = QW'(1) << (QW - 2 - 2 * m);
        assign trial = res_cur + bitv;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (v_cur >= trial) begin
                    r_v[m+1]   <= v_cur - trial;
                    r_res[m+1] <= (res_cur >> 1) + bitv;
                end else begin
                    r_v[m+1]   <= v_cur;
                    r_res[m+1] <= res_cur >> 1;
                end
                r_sat[DIV+m+1] <= r_sat[DIV+m];
                r_neg[DIV+m+1] <= r_neg[DIV+m];
            end
        end
    end

    logic [WW-1:0] mag;
    assign mag = r_sat[CHN] ? bpit_pkg::WGT_NEG_MAG : r_res[SQR][WW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[CHN]) begin
                o_weight <= $signed(~mag + WW'(1));
                o_inr    <= (mag == '0);
            end else begin
                o_weight <= $signed((mag > bpit_pkg::WGT_MAX) ? bpit_pkg::WGT_MAX : mag);
                o_inr    <= (mag <= bpit_pkg::ONE_Q16);
            end
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/barycentric_point_in_triangle.sv
`default_nettype none
// ----------------------------------------------------------------------------
// barycentric_point_in_triangle
// Exact 3D barycentric weights and inside test for Q16.16 points.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the output is not stalled. Each
// result passes through the difference, cross product and split dot product
// stages, then 38 divider stages (one quotient bit each) and 19 square root
// stages. A stall on the output holds the whole pipeline in place.
module barycentric_point_in_triangle (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic signed [31:0]   i_point_x,
    input  wire logic signed [31:0]   i_point_y,
    input  wire logic signed [31:0]   i_point_z,
    input  wire logic signed [31:0]   i_corner_a_x,
    input  wire logic signed [31:0]   i_corner_a_y,
    input  wire logic signed [31:0]   i_corner_a_z,
    input  wire logic signed [31:0]   i_corner_b_x,
    input  wire logic signed [31:0]   i_corner_b_y,
    input  wire logic signed [31:0]   i_corner_b_z,
    input  wire logic signed [31:0]   i_corner_c_x,
    input  wire logic signed [31:0]   i_corner_c_y,
    input  wire logic signed [31:0]   i_corner_c_z,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic signed [19:0]        o_weight_a,
    output logic signed [19:0]        o_weight_b,
    output logic signed [19:0]        o_weight_c,
    output logic                      o_inside_res,
    output logic                      o_degenerate
);

    localparam int DF   = bpit_pkg::DIF_W;
    localparam int SW   = bpit_pkg::SQ_W;
    localparam int DW   = bpit_pkg::DOT_W;
    localparam int WW   = bpit_pkg::WGT_W;
    localparam int RL   = bpit_pkg::RATIO_LAT;
    localparam int PIPE = 1 + bpit_pkg::CROSS_LAT + bpit_pkg::DOT_LAT + RL;

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic signed [31:0] pt [3];
    logic signed [31:0] vx [3][3];

    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;
    assign vx[0][0] = i_corner_a_x;
    assign vx[0][1] = i_corner_a_y;
    assign vx[0][2] = i_corner_a_z;
    assign vx[1][0] = i_corner_b_x;
    assign vx[1][1] = i_corner_b_y;
    assign vx[1][2] = i_corner_b_z;
    assign vx[2][0] = i_corner_c_x;
    assign vx[2][1] = i_corner_c_y;
    assign vx[2][2] = i_corner_c_z;

    // valid chain, one bit per stage up to the ratio outputs
    logic r_vld [0:PIPE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < PIPE; s++) begin
                r_vld[s] <= 1'b0;
            end
            o_valid <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < PIPE; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
            o_valid <= r_vld[PIPE-1];
        end
    end

    // edge differences
    bpit_pkg::t_dif_vec r_e01, r_e02;
    bpit_pkg::t_dif_vec r_edge [3];
    bpit_pkg::t_dif_vec r_tp   [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_e01[i] <= DF'(vx[1][i]) - DF'(vx[0][i]);
                r_e02[i] <= DF'(vx[2][i]) - DF'(vx[0][i]);
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_edge
        localparam int FR = (k + 1) % 3;
        localparam int TO = (k + 2) % 3;
        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    r_edge[k][i] <= DF'(vx[TO][i]) - DF'(vx[FR][i]);
                    r_tp[k][i]   <= DF'(pt[i]) - DF'(vx[FR][i]);
                end
            end
        end
    end

    // normals
    bpit_pkg::t_crs_vec nrm;
    bpit_pkg::t_crs_vec sub [3];

    bpit_cross u_cross_n (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_e02),
        .i_b   (r_e01),
        .o_c   (nrm)
    );

    bpit_pkg::t_dot nn;

    bpit_dot u_dot_nn (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (nrm),
        .i_b   (nrm),
        .o_dot (nn)
    );

    logic signed [WW-1:0] wgt [3];
    logic                 inr [3];

    for (genvar k = 0; k < 3; k++) begin : g_wgt
        bpit_pkg::t_dot ns, ss;

        bpit_cross u_cross (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (r_tp[k]),
            .i_b   (r_edge[k]),
            .o_c   (sub[k])
        );

        bpit_dot u_dot_ns (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (nrm),
            .i_b   (sub[k]),
            .o_dot (ns)
        );

        bpit_dot u_dot_ss (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (sub[k]),
            .i_b   (sub[k]),
            .o_dot (ss)
        );

        bpit_ratio u_ratio (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_s      (ss[SW-1:0]),
            .i_t      (nn[SW-1:0]),
            .i_neg    (ns[DW-1]),
            .o_weight (wgt[k]),
            .o_inr    (inr[k])
        );
    end

    // zero-area flag rides alongside the ratio stages
    logic r_deg [0:RL-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_deg[0] <= (nn == '0);
            for (int s = 1; s < RL; s++) begin
                r_deg[s] <= r_deg[s-1];
            end
        end
    end

    logic deg;
    assign deg = r_deg[RL-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_weight_a   <= deg ? '0 : wgt[0];
            o_weight_b   <= deg ? '0 : wgt[1];
            o_weight_c   <= deg ? '0 : wgt[2];
            o_inside_res <= !deg && inr[0] && inr[1] && inr[2];
            o_degenerate <= deg;
        end
    end

endmodule
`default_nettype wire
